/* rtl/core/grm_pkg.sv */
// Shared types, op codes and default sizes for the greedy rectangle merge block.
`default_nettype none
package grm_pkg;

	localparam int GRID_SIDE_DEF  = 16;
	localparam int VALUE_BITS_DEF = 16;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_FETCH   = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  cell_row;
		logic [3:0]  cell_col;
		logic [15:0] cell_value;
	} cmd_t;

	typedef struct packed {
		logic        rect_valid;
		logic [3:0]  rect_col;
		logic [3:0]  rect_row;
		logic [4:0]  rect_width;
		logic [4:0]  rect_height;
		logic [15:0] rect_value;
	} res_t;

endpackage
`default_nettype wire

/* rtl/core/greedy_rectangle_merge.sv */
// Greedy rectangle merge: top level with row memory, used marks and fetch sequencer.
// The grid is held one row per memory word, and one row compare unit checks a whole row
// against a reference value. A cell write reads the row, modifies the cell and writes the
// row back. A restart completes as the command is taken. A fetch takes the command, reads
// and searches rows for a start cell, takes the start row's run, reads and tries each
// further row below it, and hands the transaction to the result register. A fetch that
// finds no start cell hands over an empty transaction after its search, and one after the
// scan has finished goes straight to the hand-off. The hand-off waits while an earlier
// result still waits on res_stall. Each row visited is fetched by a registered read of the
// row memory before it is compared. No new command is taken until the current one finishes.
// Rows never written read as empty through a valid bit per row, so no clearing pass follows
// reset.
`default_nettype none
module greedy_rectangle_merge #(
	parameter int GRID_SIDE  = grm_pkg::GRID_SIDE_DEF,
	parameter int VALUE_BITS = grm_pkg::VALUE_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire grm_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_stall,
	output grm_pkg::res_t      res
);

	localparam int IDX_W    = $clog2(GRID_SIDE);
	localparam int CNT_W    = $clog2(GRID_SIDE + 1);
	localparam int ROW_BITS = GRID_SIDE * VALUE_BITS;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FRD  = 4'd1;
	localparam logic [3:0] S_FIND = 4'd2;
	localparam logic [3:0] S_RUN  = 4'd3;
	localparam logic [3:0] S_DRD  = 4'd4;
	localparam logic [3:0] S_DOWN = 4'd5;
	localparam logic [3:0] S_EMIT = 4'd6;
	localparam logic [3:0] S_WRD  = 4'd7;
	localparam logic [3:0] S_WMOD = 4'd8;

	logic [3:0]            state_q;
	logic [IDX_W-1:0]      cur_row_q;
	logic [IDX_W-1:0]      scan_row_q;
	logic [IDX_W-1:0]      scan_col_q;
	logic                  done_q;
	logic [IDX_W-1:0]      sr_q;
	logic [IDX_W-1:0]      sc_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CNT_W-1:0]      w_q;
	logic [CNT_W-1:0]      h_q;
	logic [GRID_SIDE-1:0]  span_q;
	logic                  hit_q;
	logic [IDX_W-1:0]      wcol_q;
	logic [VALUE_BITS-1:0] wval_q;
	logic [GRID_SIDE-1:0]  rv_q;
	logic [GRID_SIDE-1:0]  used_q [GRID_SIDE];
	logic                  out_valid_q;
	grm_pkg::res_t         out_q;

	logic [ROW_BITS-1:0]   rdata;
	logic [ROW_BITS-1:0]   row_eff;
	logic [ROW_BITS-1:0]   wrow;
	logic [VALUE_BITS-1:0] ref_val;
	logic [GRID_SIDE-1:0]  eq;
	logic [GRID_SIDE-1:0]  free_c;
	logic [GRID_SIDE-1:0]  colm_c;
	logic [GRID_SIDE-1:0]  cand_c;
	logic [GRID_SIDE-1:0]  match_c;
	logic [GRID_SIDE-1:0]  shifted_c;
	logic [GRID_SIDE-1:0]  span_c;
	logic [IDX_W-1:0]      first_c;
	logic                  any_c;
	logic [CNT_W-1:0]      w_c;
	logic                  last_row;
	logic                  row_fits;
	logic                  down_ok;

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	assign row_eff  = rv_q[cur_row_q] ? rdata : '0;
	assign ref_val  = (state_q == S_FIND) ? '0 : val_q;
	assign free_c   = ~used_q[cur_row_q];
	assign cand_c   = ~eq & free_c & colm_c;
	assign match_c  = eq & free_c;
	assign last_row = (cur_row_q == IDX_W'(GRID_SIDE - 1));
	assign row_fits = (int'(cmd.cell_row) < GRID_SIDE) && (int'(cmd.cell_col) < GRID_SIDE);
	assign down_ok  = ((match_c & span_q) == span_q);

	grm_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(GRID_SIDE)
	) u_rows (
		.clk  (clk),
		.we   (state_q == S_WMOD),
		.waddr(cur_row_q),
		.wdata(wrow),
		.raddr(cur_row_q),
		.rdata(rdata)
	);

	grm_row_cmp #(
		.GRID_SIDE (GRID_SIDE),
		.VALUE_BITS(VALUE_BITS)
	) u_cmp (
		.row_data(row_eff),
		.ref_val (ref_val),
		.eq      (eq)
	);

	always_comb begin
		for (int k = 0; k < GRID_SIDE; k++) begin
			colm_c[k] = (k >= int'(scan_col_q));
		end
	end

	always_comb begin
		first_c = '0;
		any_c   = 1'b0;
		for (int k = GRID_SIDE - 1; k >= 0; k--) begin
			if (cand_c[k]) begin
				first_c = IDX_W'(k);
				any_c   = 1'b1;
			end
		end
	end

	always_comb begin
		shifted_c = match_c >> sc_q;
		w_c       = CNT_W'(GRID_SIDE);
		for (int k = GRID_SIDE - 1; k >= 0; k--) begin
			if (!shifted_c[k]) begin
				w_c = CNT_W'(k);
			end
		end
		for (int k = 0; k < GRID_SIDE; k++) begin
			span_c[k] = (k >= int'(sc_q)) && (k < int'(sc_q) + int'(w_c));
		end
	end

	always_comb begin
		wrow = row_eff;
		wrow[wcol_q*VALUE_BITS +: VALUE_BITS] = wval_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_row_q   <= '0;
			scan_row_q  <= '0;
			scan_col_q  <= '0;
			done_q      <= 1'b0;
			sr_q        <= '0;
			sc_q        <= '0;
			val_q       <= '0;
			w_q         <= '0;
			h_q         <= '0;
			span_q      <= '0;
			hit_q       <= 1'b0;
			wcol_q      <= '0;
			wval_q      <= '0;
			rv_q        <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int r = 0; r < GRID_SIDE; r++) begin
				used_q[r] <= '0;
			end
		end else begin
			if (out_valid_q && !res_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.op)
							grm_pkg::OP_WRITE: begin
								if (row_fits) begin
									cur_row_q <= IDX_W'(cmd.cell_row);
									wcol_q    <= IDX_W'(cmd.cell_col);
									wval_q    <= VALUE_BITS'(cmd.cell_value);
									state_q   <= S_WRD;
								end
							end
							grm_pkg::OP_RESTART: begin
								scan_row_q <= '0;
								scan_col_q <= '0;
								done_q     <= 1'b0;
								for (int r = 0; r < GRID_SIDE; r++) begin
									used_q[r] <= '0;
								end
							end
							grm_pkg::OP_FETCH: begin
								if (done_q) begin
									hit_q   <= 1'b0;
									state_q <= S_EMIT;
								end else begin
									cur_row_q <= scan_row_q;
									state_q   <= S_FRD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FRD: begin
					state_q <= S_FIND;
				end
				S_FIND: begin
					if (any_c) begin
						sc_q    <= first_c;
						sr_q    <= cur_row_q;
						val_q   <= row_eff[first_c*VALUE_BITS +: VALUE_BITS];
						state_q <= S_RUN;
					end else begin
						scan_col_q <= '0;
						if (last_row) begin
							done_q  <= 1'b1;
							hit_q   <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							cur_row_q  <= cur_row_q + IDX_W'(1);
							scan_row_q <= cur_row_q + IDX_W'(1);
							state_q    <= S_FRD;
						end
					end
				end
				S_RUN: begin
					w_q               <= w_c;
					h_q               <= CNT_W'(1);
					span_q            <= span_c;
					hit_q             <= 1'b1;
					used_q[cur_row_q] <= used_q[cur_row_q] | span_c;
					if (sc_q == IDX_W'(GRID_SIDE - 1)) begin
						scan_col_q <= '0;
						if (last_row) begin
							done_q <= 1'b1;
						end else begin
							scan_row_q <= sr_q + IDX_W'(1);
						end
					end else begin
						scan_col_q <= sc_q + IDX_W'(1);
					end
					if (last_row) begin
						state_q <= S_EMIT;
					end else begin
						cur_row_q <= cur_row_q + IDX_W'(1);
						state_q   <= S_DRD;
					end
				end
				S_DRD: begin
					state_q <= S_DOWN;
				end
				S_DOWN: begin
					if (down_ok) begin
						used_q[cur_row_q] <= used_q[cur_row_q] | span_q;
						h_q               <= h_q + CNT_W'(1);
						if (last_row) begin
							state_q <= S_EMIT;
						end else begin
							cur_row_q <= cur_row_q + IDX_W'(1);
							state_q   <= S_DRD;
						end
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || !res_stall) begin
						out_valid_q       <= 1'b1;
						out_q.rect_valid  <= hit_q;
						out_q.rect_col    <= hit_q ? 4'(sc_q) : '0;
						out_q.rect_row    <= hit_q ? 4'(sr_q) : '0;
						out_q.rect_width  <= hit_q ? 5'(w_q) : '0;
						out_q.rect_height <= hit_q ? 5'(h_q) : '0;
						out_q.rect_value  <= hit_q ? 16'(val_q) : '0;
						state_q           <= S_IDLE;
					end
				end
				S_WRD: begin
					state_q <= S_WMOD;
				end
				S_WMOD: begin
					rv_q[cur_row_q] <= 1'b1;
					state_q         <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_down_sizes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DOWN |-> (h_q != '0) && (w_q != '0))
		else $error("rectangle size zero during downward extension");

	a_find_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIND |-> !done_q)
		else $error("search started after scan finished");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.rect_valid |->
			res.rect_width == '0 && res.rect_height == '0 && res.rect_value == '0)
		else $error("finished-scan transaction carries nonzero fields");

	a_run_marks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |=> (span_q != '0))
		else $error("start run covers no cell");

endmodule
`default_nettype wire

/* rtl/core/grm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module grm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/grm_row_cmp.sv */
// Row-wide compare unit: every cell of one grid row against one reference value.
`default_nettype none
module grm_row_cmp #(
	parameter int GRID_SIDE  = grm_pkg::GRID_SIDE_DEF,
	parameter int VALUE_BITS = grm_pkg::VALUE_BITS_DEF
) (
	input  wire logic [GRID_SIDE*VALUE_BITS-1:0] row_data,
	input  wire logic [VALUE_BITS-1:0]           ref_val,
	output logic      [GRID_SIDE-1:0]            eq
);

	always_comb begin
		for (int k = 0; k < GRID_SIDE; k++) begin
			eq[k] = (row_data[k*VALUE_BITS +: VALUE_BITS] == ref_val);
		end
	end

endmodule
`default_nettype wire

/* sim/grm_rect_checker.sv */
// Rectangle checker: tracks the grid from accepted commands and compares every result.
`timescale 1ns / 100ps
module grm_rect_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire logic          cmd_stall,
	input  wire grm_pkg::cmd_t cmd,
	input  wire logic          res_valid,
	input  wire logic          res_stall,
	input  wire grm_pkg::res_t res,
	output int                 fail_count,
	output int                 open_count
);

	localparam int SIDE  = grm_pkg::GRID_SIDE_DEF;
	localparam int CELLS = SIDE * SIDE;

	logic [15:0]   grid [CELLS];
	bit            used [CELLS];
	int            scan_pos;
	grm_pkg::res_t pending_rects [$];
	int            fails = 0;

	function automatic bit free_match(int idx, logic [15:0] v);
		if (idx >= CELLS)
			return 1'b0;
		return !used[idx] && grid[idx] == v;
	endfunction

	function automatic grm_pkg::res_t next_rect();
		grm_pkg::res_t r;
		int            start, srow, scol, w, h, i, k;
		logic [15:0]   v;
		bit            ok;
		r = '0;
		while (scan_pos < CELLS && (grid[scan_pos] == '0 || used[scan_pos]))
			scan_pos++;
		if (scan_pos >= CELLS) begin
			scan_pos = CELLS;
			return r;
		end
		start = scan_pos;
		srow  = start / SIDE;
		scol  = start % SIDE;
		v     = grid[start];
		w     = 1;
		h     = 1;
		while (scol + w < SIDE && free_match(start + w, v))
			w++;
		ok = 1'b1;
		while (ok && srow + h < SIDE) begin
			for (k = 0; k < w; k++)
				if (!free_match(start + h * SIDE + k, v))
					ok = 1'b0;
			if (ok)
				h++;
		end
		for (i = 0; i < h; i++)
			for (k = 0; k < w; k++)
				used[start + i * SIDE + k] = 1'b1;
		scan_pos      = start + 1;
		r.rect_valid  = 1'b1;
		r.rect_col    = 4'(scol);
		r.rect_row    = 4'(srow);
		r.rect_width  = 5'(w);
		r.rect_height = 5'(h);
		r.rect_value  = v;
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	task automatic check_rect(grm_pkg::res_t got);
		grm_pkg::res_t want;
		if (pending_rects.size() == 0) begin
			$error("result transaction with no fetch pending");
			fails++;
			return;
		end
		want = pending_rects.pop_front();
		check_field("rect_valid", int'(want.rect_valid), int'(got.rect_valid));
		check_field("rect_col", int'(want.rect_col), int'(got.rect_col));
		check_field("rect_row", int'(want.rect_row), int'(got.rect_row));
		check_field("rect_width", int'(want.rect_width), int'(got.rect_width));
		check_field("rect_height", int'(want.rect_height), int'(got.rect_height));
		check_field("rect_value", int'(want.rect_value), int'(got.rect_value));
	endtask

	task automatic apply_cmd(grm_pkg::cmd_t c);
		case (c.op)
			grm_pkg::OP_WRITE: begin
				grid[{c.cell_row, c.cell_col}] = c.cell_value;
			end
			grm_pkg::OP_RESTART: begin
				foreach (used[i])
					used[i] = 1'b0;
				scan_pos = 0;
			end
			grm_pkg::OP_FETCH: begin
				pending_rects.push_back(next_rect());
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (grid[i]) begin
				grid[i] = '0;
				used[i] = 1'b0;
			end
			scan_pos = 0;
			pending_rects.delete();
			open_count <= 0;
			fail_count <= fails;
		end else begin
			// result first, so a fetch taken this edge cannot cover a stray result
			if (res_valid && !res_stall)
				check_rect(res);
			if (cmd_valid && !cmd_stall)
				apply_cmd(cmd);
			open_count <= pending_rects.size();
			fail_count <= fails;
		end
	end

endmodule

/* sim/tb_greedy_rectangle_merge.sv */
// Top of the greedy rectangle merge testbench: clock, reset, command and result stimulus.
`timescale 1ns / 100ps
module tb_greedy_rectangle_merge;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         TARGET    = 550;
	localparam int         CMD_BITS  = $bits(grm_pkg::cmd_t);
	localparam int         SIDE      = grm_pkg::GRID_SIDE_DEF;

	logic          clk;
	logic          arst_n;
	logic          cmd_valid;
	logic          cmd_stall;
	grm_pkg::cmd_t cmd;
	logic          res_valid;
	logic          res_stall;
	grm_pkg::res_t res;
	int            fail_count;
	int            open_count;

	int   items_sent  = 0;
	int   hold_asked  = 0;
	int   hold_served = 0;
	bit   calm        = 1'b0;

	greedy_rectangle_merge DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	grm_rect_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.fail_count(fail_count),
		.open_count(open_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#15_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 16'($urandom_range(1, 3));
		if (r < 70)
			return 16'hFFFF;
		if (r < 95)
			return 16'($urandom);
		return '0;
	endfunction

	task automatic send_cmd(logic [1:0] op, int row, int col, logic [15:0] val, bit quick = 0);
		grm_pkg::cmd_t c;
		int            gap;
		c.op         = op;
		c.cell_row   = 4'(row);
		c.cell_col   = 4'(col);
		c.cell_value = val;
		gap = quick ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			cmd       <= grm_pkg::cmd_t'(CMD_BITS'($urandom));
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic paint(int r0, int c0, int h, int w, logic [15:0] v);
		int r, c;
		for (r = r0; r < r0 + h && r < SIDE; r++)
			for (c = c0; c < c0 + w && c < SIDE; c++)
				send_cmd(grm_pkg::OP_WRITE, r, c, v);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
	endtask

	// result side: random stalls, plus one long hold when asked
	initial begin : result_side
		int s, f;
		res_stall <= 1'b0;
		forever begin
			if (hold_served < hold_asked) begin
				hold_served++;
				res_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else begin
				s = pick_gap();
				f = ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(5, 30);
				if (s > 0) begin
					res_stall <= 1'b1;
					repeat (s) @(posedge clk);
				end
				res_stall <= 1'b0;
				repeat (f) @(posedge clk);
			end
		end
	end

	initial begin : command_side
		int          nrect, kind, h, w, r0, c0, nfetch, k, episode;
		logic [15:0] v;
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty grid, 2x2 block at the corner, runs broken by value, edge cells
		send_cmd(grm_pkg::OP_FETCH, 0, 0, '0);
		paint(0, 0, 2, 2, 16'hFFFF);
		send_cmd(grm_pkg::OP_WRITE, 0, 2, 16'h0001);
		send_cmd(grm_pkg::OP_WRITE, 15, 15, 16'h0001);
		send_cmd(grm_pkg::OP_WRITE, 15, 0, 16'h8000);
		send_cmd(grm_pkg::OP_WRITE, 0, 15, 16'h0001);
		send_cmd(grm_pkg::OP_WRITE, 1, 15, 16'h0001);
		send_cmd(grm_pkg::OP_RESTART, 0, 0, '0);
		repeat (6) send_cmd(grm_pkg::OP_FETCH, 0, 0, '0);
		// finished scan repeats until restart
		send_cmd(grm_pkg::OP_FETCH, 15, 15, 16'hFFFF);
		send_cmd(OP_UNUSED, 15, 15, 16'hFFFF);
		// write behind the scan position, seen only after restart
		send_cmd(grm_pkg::OP_WRITE, 0, 3, 16'h0001);
		send_cmd(grm_pkg::OP_FETCH, 0, 0, '0);
		send_cmd(grm_pkg::OP_WRITE, 0, 0, '0);
		send_cmd(grm_pkg::OP_RESTART, 0, 0, '0);
		send_cmd(grm_pkg::OP_FETCH, 0, 0, '0);
		send_cmd(grm_pkg::OP_FETCH, 0, 0, '0);

		episode = 0;
		while (items_sent < TARGET) begin
			if ($urandom_range(4) == 0)
				calm = ~calm;
			nrect = $urandom_range(1, 4);
			for (k = 0; k < nrect; k++) begin
				kind = $urandom_range(11);
				v    = pick_value();
				if (kind == 0)
					paint($urandom_range(15), 0, 1, SIDE, v);
				else if (kind == 1)
					paint(0, $urandom_range(15), SIDE, 1, v);
				else begin
					h  = $urandom_range(1, 3);
					w  = $urandom_range(1, 3);
					r0 = $urandom_range(15);
					c0 = $urandom_range(15);
					paint(r0, c0, h, w, v);
				end
			end
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 4))
					send_cmd(grm_pkg::OP_WRITE, $urandom_range(15), $urandom_range(15),
						16'($urandom));
			if ($urandom_range(9) != 0)
				send_cmd(grm_pkg::OP_RESTART, $urandom_range(15), $urandom_range(15),
					16'($urandom));
			if (episode == 3) begin
				hold_asked++;
				cmd_valid <= 1'b0;
				wait (hold_served == hold_asked);
				repeat (16) send_cmd(grm_pkg::OP_FETCH, 0, 0, '0, 1'b1);
			end
			nfetch = $urandom_range(2, 12);
			for (k = 0; k < nfetch; k++) begin
				send_cmd(grm_pkg::OP_FETCH, $urandom_range(15), $urandom_range(15),
					16'($urandom));
				if ($urandom_range(9) == 0)
					send_cmd(grm_pkg::OP_WRITE, $urandom_range(15), $urandom_range(15),
						pick_value());
				if ($urandom_range(19) == 0)
					send_cmd(OP_UNUSED, $urandom_range(15), $urandom_range(15),
						16'($urandom));
			end
			if (episode == 1 || $urandom_range(3) == 0)
				wait_drained();
			episode++;
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && open_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
